/* rtl/core/uartrb_pkg.sv */
// ----------------------------------------------------------------------------
// uartrb_pkg
// Shared types and codes for the UART receive/transmit ring buffer block.
// ----------------------------------------------------------------------------
package uartrb_pkg;

	typedef enum logic [1:0] {
		MODE_TX_PUSH = 2'd0,
		MODE_RX_POP  = 2'd1,
		MODE_IRQ     = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] byte_in;
		logic       rx_ready;
		logic       tx_empty;
	} req_beat_t;

	typedef struct packed {
		logic       accepted;
		logic [7:0] read_byte;
		logic       tx_send;
		logic [7:0] tx_byte;
		logic       tx_irq_enable;
	} rsp_beat_t;

	// ring command and status
	typedef struct packed {
		logic push;
		logic pop;
	} ring_cmd_t;

	typedef struct packed {
		logic full;
		logic empty;
	} ring_stat_t;

endpackage

/* rtl/core/uartrb_if.sv */
// ----------------------------------------------------------------------------
// uartrb_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface uartrb_req_if;
	logic                  valid;
	logic                  ready;
	uartrb_pkg::req_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface uartrb_rsp_if;
	logic                  valid;
	logic                  ready;
	uartrb_pkg::rsp_beat_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/core/uartrb_ram.sv */
// ----------------------------------------------------------------------------
// uartrb_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module uartrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/core/uartrb_ring.sv */
// ----------------------------------------------------------------------------
// uartrb_ring
// Byte ring with one-slot-empty full detection; pop data is registered.
// ----------------------------------------------------------------------------
module uartrb_ring #(
	parameter int DEPTH = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  uartrb_pkg::ring_cmd_t  cmd,
	input  logic [7:0]             wdata,
	output uartrb_pkg::ring_stat_t stat,
	output logic [7:0]             rdata
);

	localparam int AW = $clog2(DEPTH);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [AW-1:0] wr_nxt, rd_nxt;

	assign wr_nxt = (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_nxt = (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;

	assign stat.full  = (wr_nxt == rd_ptr_q);
	assign stat.empty = (wr_ptr_q == rd_ptr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (cmd.push) begin
				wr_ptr_q <= wr_nxt;
			end
			if (cmd.pop) begin
				rd_ptr_q <= rd_nxt;
			end
		end
	end

	uartrb_ram #(
		.WIDTH(8),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (cmd.push),
		.waddr(wr_ptr_q),
		.wdata(wdata),
		.re   (cmd.pop),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

endmodule

/* rtl/core/uart_rx_tx_ring_buffers.sv */
// ----------------------------------------------------------------------------
// uart_rx_tx_ring_buffers
// UART receive and transmit byte rings with interrupt-driven transmit.
// ----------------------------------------------------------------------------
// Each response beat is registered, valid in the cycle after its request is taken.
// Throughput: one beat per cycle; each ring RAM is read only on a pop of that ring.
// Ready drops only while a response beat is held by a stalled sink.
// Reset (arst_n low): ring pointers, tx interrupt enable and response valid
// clear at once; ring contents are left as they are.
module uart_rx_tx_ring_buffers #(
	parameter int RX_DEPTH = 64,
	parameter int TX_DEPTH = 64
) (
	input logic          clk,
	input logic          arst_n,
	uartrb_req_if.sink   req,
	uartrb_rsp_if.source rsp
);

	uartrb_pkg::ring_cmd_t  rx_cmd, tx_cmd;
	uartrb_pkg::ring_stat_t rx_stat, tx_stat;
	logic [7:0]             rx_rdata, tx_rdata;

	logic take;
	logic tx_en_q, tx_en_nxt;
	logic acc_nxt;
	logic valid_s1, acc_s1, rd_s1, send_s1, en_s1;

	assign req.ready = !valid_s1 || rsp.ready;
	assign take      = req.valid && req.ready;

	always_comb begin
		rx_cmd    = '0;
		tx_cmd    = '0;
		acc_nxt   = 1'b0;
		tx_en_nxt = tx_en_q;
		unique case (uartrb_pkg::mode_t'(req.data.mode))
			uartrb_pkg::MODE_TX_PUSH: begin
				if (!tx_stat.full) begin
					tx_cmd.push = 1'b1;
					tx_en_nxt   = 1'b1;
					acc_nxt     = 1'b1;
				end
			end
			uartrb_pkg::MODE_RX_POP: begin
				if (!rx_stat.empty) begin
					rx_cmd.pop = 1'b1;
					acc_nxt    = 1'b1;
				end
			end
			uartrb_pkg::MODE_IRQ: begin
				if (req.data.rx_ready && !rx_stat.full) begin
					rx_cmd.push = 1'b1;
					acc_nxt     = 1'b1;
				end
				if (req.data.tx_empty && tx_en_q) begin
					if (tx_stat.empty) begin
						tx_en_nxt = 1'b0;
					end else begin
						tx_cmd.pop = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		if (!take) begin
			rx_cmd    = '0;
			tx_cmd    = '0;
			tx_en_nxt = tx_en_q;
		end
	end

	uartrb_ring #(.DEPTH(RX_DEPTH)) u_rx_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (rx_cmd),
		.wdata (req.data.byte_in),
		.stat  (rx_stat),
		.rdata (rx_rdata)
	);

	uartrb_ring #(.DEPTH(TX_DEPTH)) u_tx_ring (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (tx_cmd),
		.wdata (req.data.byte_in),
		.stat  (tx_stat),
		.rdata (tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_en_q  <= 1'b0;
			valid_s1 <= 1'b0;
		end else begin
			tx_en_q <= tx_en_nxt;
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			acc_s1  <= acc_nxt;
			rd_s1   <= rx_cmd.pop;
			send_s1 <= tx_cmd.pop;
			en_s1   <= tx_en_nxt;
		end
	end

	// ring read data is held until the next pop, so it stays valid while stalled
	assign rsp.valid              = valid_s1;
	assign rsp.data.accepted      = acc_s1;
	assign rsp.data.read_byte     = rd_s1 ? rx_rdata : 8'h00;
	assign rsp.data.tx_send       = send_s1;
	assign rsp.data.tx_byte       = send_s1 ? tx_rdata : 8'h00;
	assign rsp.data.tx_irq_enable = en_s1;

endmodule

/* rtl/core/uartrb_chk.sv */
// ----------------------------------------------------------------------------
// uartrb_chk
// Port-level checks for uart_rx_tx_ring_buffers, bound to the top level.
// ----------------------------------------------------------------------------
module uartrb_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       req_valid,
	input logic       req_ready,
	input logic       rsp_valid,
	input logic       rsp_ready,
	input logic       accepted,
	input logic [7:0] read_byte,
	input logic       tx_send,
	input logic [7:0] tx_byte,
	input logic       tx_irq_enable
);

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("response beat dropped while stalled");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("no response one cycle after request beat");

	a_send_en: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && tx_send |-> tx_irq_enable)
		else $error("tx byte sent with interrupt enable clear");

	a_read_acc: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (read_byte != 8'h00) |-> accepted)
		else $error("read byte shown without accept");

	a_txb_send: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (tx_byte != 8'h00) |-> tx_send)
		else $error("tx byte shown without send");

endmodule

bind uart_rx_tx_ring_buffers uartrb_chk u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.req_valid    (req.valid),
	.req_ready    (req.ready),
	.rsp_valid    (rsp.valid),
	.rsp_ready    (rsp.ready),
	.accepted     (rsp.data.accepted),
	.read_byte    (rsp.data.read_byte),
	.tx_send      (rsp.data.tx_send),
	.tx_byte      (rsp.data.tx_byte),
	.tx_irq_enable(rsp.data.tx_irq_enable)
);
